// ===== sv/sdrc_pkg.sv =====
// sdrc_pkg: shared types, fixed-point constants and table builders for the compressor
// used by sdrc_ctrl and static_dynamic_range_compressor_core; depends on nothing
`default_nettype none

package sdrc_pkg;

    // defaults for the top-level parameters
    localparam int unsigned SAMPLE_BITS_DEF        = 16;
    localparam int unsigned GAIN_TABLE_ENTRIES_DEF = 256;

    // pipeline depth, input register to output register
    localparam int unsigned NUM_STAGES = 13;

    // register file
    localparam int unsigned CFG_W = 16;
    localparam logic signed [CFG_W-1:0] THRESHOLD_RESET = -16'sd5120;
    localparam logic        [CFG_W-1:0] SLOPE_RESET     = 16'd49152;

    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0,
        REG_SLOPE     = 1'b1
    } cfg_reg_t;

    // fixed-point formats
    localparam int unsigned FRAC_W     = 30;    // normalized mantissa fraction, Q30
    localparam int unsigned LOG_W      = 17;    // log2 table entries, Q16 up to 1.0
    localparam int unsigned GAIN_W     = 31;    // exp2 table entries, Q30 up to 1.0
    localparam int unsigned DEPTH_W    = 16;    // level below full scale, dB * 256
    localparam int unsigned LEVEL_W    = 17;    // signed level and excess
    localparam int unsigned RED_W      = 16;    // reduction, dB * 256
    localparam int unsigned R_W        = 22;    // reduction in log2 units, Q16
    localparam int unsigned K_W        = 6;     // integer part of the reduction
    localparam int unsigned Q16_BITS   = 16;
    localparam int unsigned GAIN_FRAC  = 30;

    localparam int unsigned DB_CONST_W  = 19;
    localparam int unsigned LOG_CONST_W = 22;
    localparam logic [DB_CONST_W-1:0]  DB256_PER_LOG2 = 19'd394566;   // 20*log10(2)*256, Q8
    localparam logic [LOG_CONST_W-1:0] LOG2_PER_DB256 = 22'd2786635;  // log2(10)/20/256, Q32
    localparam int unsigned DEPTH_SHIFT = 24;
    localparam int unsigned R_SHIFT     = 16;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } sdrc_pipe_t;

    // long division for building the tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] acc;
        logic [63:0] res;
        logic [63:0] probe;
        acc   = v;
        res   = '0;
        probe = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (acc >= res + probe) begin
                acc = acc - (res + probe);
                res = (res >> 1) + probe;
            end
            else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/n) in Q16 by repeated squaring, truncated
    function automatic logic [LOG_W-1:0] log_entry(input int unsigned i, input int unsigned n);
        logic [63:0]      z;
        logic [LOG_W-1:0] y;
        y = '0;
        if (i >= n) begin
            y = LOG_W'(65536);
        end
        else begin
            z = ONE_Q30 + udiv64(64'(i) << 30, 64'(n));
            for (int b = 15; b >= 0; b--) begin
                z = (z * z) >> 30;
                if (z >= (ONE_Q30 << 1)) begin
                    z    = z >> 1;
                    y[b] = 1'b1;
                end
            end
        end
        return y;
    endfunction

    // 2^(-i/n) in Q30 as a product of 2^(-2^-b) factors
    function automatic logic [GAIN_W-1:0] exp_entry(input int unsigned i, input int unsigned n);
        logic [63:0] f;
        logic [63:0] g;
        logic [63:0] root;
        f    = udiv64(64'(i) << 16, 64'(n));
        g    = ONE_Q30;
        root = ONE_Q30 >> 1;
        for (int b = 1; b <= 16; b++) begin
            root = isqrt64(root << 30);
            if (f[16-b])
                g = (g * root) >> 30;
        end
        return GAIN_W'(g);
    endfunction

endpackage

`default_nettype wire

// ===== sv/sdrc_ctrl.sv =====
// sdrc_ctrl: valid bits and per-stage load enables of the compressor pipeline
// depends on sdrc_pkg
`default_nettype none

module sdrc_ctrl
    import sdrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       out_ready,
    output sdrc_pipe_t      pipe
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] upstream;

    // a stage takes a new word when it is empty or its own word moves on
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES-2; i >= 0; i--)
            load[i] = !valid_reg[i] || load[i+1];
    end

    assign upstream   = {valid_reg[NUM_STAGES-2:0], in_valid};
    assign valid_next = (load & upstream) | (~load & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign pipe.load  = load;
    assign pipe.valid = valid_reg;

    // words in flight change only by accepted input and delivered output
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> ($countones(valid_reg) == $countones($past(valid_reg))
                   + ($past(in_valid && load[0]) ? 1 : 0)
                   - ($past(valid_reg[NUM_STAGES-1] && out_ready) ? 1 : 0)))
        else $error("sdrc_ctrl: word count mismatch");

    // a ready receiver frees the whole chain
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> load[0])
        else $error("sdrc_ctrl: input stalled while output ready");

    // a held stage keeps its word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> ((valid_reg & $past(valid_reg & ~load)) == $past(valid_reg & ~load)))
        else $error("sdrc_ctrl: stalled word lost");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |-> load[0])
        else $error("sdrc_ctrl: empty pipeline refuses input");

endmodule

`default_nettype wire

// ===== sv/static_dynamic_range_compressor_core.sv =====
// static_dynamic_range_compressor_core: hard-knee compressor, one sample per cycle while out_ready is high
// depends on sdrc_pkg and sdrc_ctrl
//
// Usage
//   in channel  : in_valid / in_ready, sample_in (signed Q1.15 at 16 bits), frame_last_in
//   out channel : out_valid / out_ready, sample_out, was_reduced, frame_last_out
//   cfg channel : cfg_valid / cfg_ready, cfg_index, cfg_data; index 0 threshold_db
//                 (dBFS * 256, signed), index 1 compression_slope (Q0.16); write while idle
//   out_valid is the valid bit of the last stage, ST_OUT. One word per cycle is taken and
//   delivered in steady state while out_ready stays high. The rate is set by the 13-stage
//   datapath, in which each stage holds at most one multiplier or the reads of one table.
//   Every stage has its own valid bit and loads when empty or when its word moves on, so
//   bubbles close up; a receiver stall fills the stages one by one and only then lowers
//   in_ready. Nothing is dropped or repeated.
//   Reset empties the pipeline and sets the threshold to -20 dBFS and the slope to 0.75
//   (ratio 4:1). The log2 and exp2 tables are constants and need no fill time.
`default_nettype none

module static_dynamic_range_compressor_core
    import sdrc_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS        = SAMPLE_BITS_DEF,
    parameter int unsigned GAIN_TABLE_ENTRIES = GAIN_TABLE_ENTRIES_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    input  wire logic                          frame_last_in,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    output logic                               was_reduced,
    output logic                               frame_last_out,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [CFG_W-1:0]              cfg_data
);

    localparam int unsigned S       = SAMPLE_BITS;
    localparam int unsigned E_W     = $clog2(S);
    localparam int unsigned NB      = $clog2(GAIN_TABLE_ENTRIES + 1);
    localparam int unsigned IDX_W   = $clog2(GAIN_TABLE_ENTRIES);
    localparam int unsigned LIDX_W  = $clog2(GAIN_TABLE_ENTRIES + 1);
    localparam int unsigned POS_W   = FRAC_W + NB;
    localparam int unsigned IP_W    = LOG_W + FRAC_W;
    localparam int unsigned LG_W    = E_W + 17;
    localparam int unsigned DPROD_W = LG_W + DB_CONST_W;
    localparam int unsigned RED_P_W = 2 * RED_W;
    localparam int unsigned RPROD_W = RED_W + LOG_CONST_W;
    localparam int unsigned GP_W    = Q16_BITS + NB;
    localparam int unsigned SP_W    = S + GAIN_W;

    localparam logic [LG_W-1:0]    BELOW_BASE  = LG_W'((S - 1) * 65536);
    localparam logic [DPROD_W-1:0] DEPTH_ROUND = DPROD_W'(1) << (DEPTH_SHIFT - 1);
    localparam logic [RPROD_W-1:0] R_ROUND     = RPROD_W'(1) << (R_SHIFT - 1);

    // stage numbers
    localparam int unsigned ST_ABS    = 0;
    localparam int unsigned ST_NORM   = 1;
    localparam int unsigned ST_POS    = 2;
    localparam int unsigned ST_LUT    = 3;
    localparam int unsigned ST_INTERP = 4;
    localparam int unsigned ST_BELOW  = 5;
    localparam int unsigned ST_DEPTH  = 6;
    localparam int unsigned ST_CMP    = 7;
    localparam int unsigned ST_R      = 8;
    localparam int unsigned ST_GIDX   = 9;
    localparam int unsigned ST_GAIN   = 10;
    localparam int unsigned ST_SCALE  = 11;
    localparam int unsigned ST_OUT    = 12;

    localparam int unsigned RAW_D  = ST_OUT;
    localparam int unsigned MAG_D  = ST_SCALE;
    localparam int unsigned NZ_D   = ST_CMP;
    localparam int unsigned LAST_D = ST_OUT + 1;
    localparam int unsigned HIT_D  = ST_OUT - ST_CMP;

    // ---------------------------------------------------------------- control
    sdrc_pipe_t pipe;

    sdrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .pipe      (pipe)
    );

    assign in_ready  = pipe.load[ST_ABS];
    assign out_valid = pipe.valid[ST_OUT];

    // ---------------------------------------------------------------- registers
    logic signed [CFG_W-1:0] threshold_reg;
    logic        [CFG_W-1:0] slope_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            slope_reg     <= SLOPE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD: threshold_reg <= cfg_data;
                REG_SLOPE:     slope_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------- tables
    logic [LOG_W-1:0]  log_rom [GAIN_TABLE_ENTRIES+1];
    logic [GAIN_W-1:0] exp_rom [GAIN_TABLE_ENTRIES];

    for (genvar gi = 0; gi <= GAIN_TABLE_ENTRIES; gi++)
    begin : g_log_rom
        assign log_rom[gi] = log_entry(gi, GAIN_TABLE_ENTRIES);
    end

    for (genvar gi = 0; gi < GAIN_TABLE_ENTRIES; gi++)
    begin : g_exp_rom
        assign exp_rom[gi] = exp_entry(gi, GAIN_TABLE_ENTRIES);
    end

    // ---------------------------------------------------------------- side band
    logic [S-1:0] raw_reg  [RAW_D];
    logic         neg_reg  [RAW_D];
    logic [S-1:0] mag_reg  [MAG_D];
    logic         nz_reg   [NZ_D];
    logic         last_reg [LAST_D];
    logic         hit_reg  [HIT_D];

    logic [S-1:0] mag_next;

    assign mag_next = sample_in[S-1] ? (~sample_in + 1'b1) : sample_in;

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_ABS])
        begin
            raw_reg[0]  <= sample_in;
            neg_reg[0]  <= sample_in[S-1];
            mag_reg[0]  <= mag_next;
            nz_reg[0]   <= |sample_in;
            last_reg[0] <= frame_last_in;
        end
    end

    for (genvar gi = 1; gi < RAW_D; gi++)
    begin : g_raw
        always_ff @(posedge clk)
        begin
            if (pipe.load[gi])
            begin
                raw_reg[gi] <= raw_reg[gi-1];
                neg_reg[gi] <= neg_reg[gi-1];
            end
        end
    end

    for (genvar gi = 1; gi < MAG_D; gi++)
    begin : g_mag
        always_ff @(posedge clk)
        begin
            if (pipe.load[gi])
                mag_reg[gi] <= mag_reg[gi-1];
        end
    end

    for (genvar gi = 1; gi < NZ_D; gi++)
    begin : g_nz
        always_ff @(posedge clk)
        begin
            if (pipe.load[gi])
                nz_reg[gi] <= nz_reg[gi-1];
        end
    end

    for (genvar gi = 1; gi < LAST_D; gi++)
    begin : g_last
        always_ff @(posedge clk)
        begin
            if (pipe.load[gi])
                last_reg[gi] <= last_reg[gi-1];
        end
    end

    for (genvar gi = 1; gi < HIT_D; gi++)
    begin : g_hit
        always_ff @(posedge clk)
        begin
            if (pipe.load[ST_CMP + gi])
                hit_reg[gi] <= hit_reg[gi-1];
        end
    end

    // ---------------------------------------------------------------- normalize
    logic [E_W-1:0]    e_next;
    logic [S-1:0]      norm;
    logic [S-2:0]      frac;
    logic [FRAC_W-1:0] f30_next;
    logic [E_W-1:0]    e1_reg;
    logic [FRAC_W-1:0] f30_reg;

    // top set bit of the magnitude
    always_comb
    begin
        e_next = '0;
        for (int b = 0; b < S; b++)
            if (mag_reg[ST_NORM-1][b])
                e_next = E_W'(b);
        norm = mag_reg[ST_NORM-1] << (E_W'(S - 1) - e_next);
        frac = norm[S-2:0];
    end

    if (S - 1 <= FRAC_W)
    begin : g_frac_up
        assign f30_next = FRAC_W'(frac) << (FRAC_W - (S - 1));
    end
    else
    begin : g_frac_down
        assign f30_next = FRAC_W'(frac >> ((S - 1) - FRAC_W));
    end

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_NORM])
        begin
            e1_reg  <= e_next;
            f30_reg <= f30_next;
        end
    end

    // ---------------------------------------------------------------- table position
    logic [POS_W-1:0]  pos;
    logic [IDX_W-1:0]  tidx_reg;
    logic [FRAC_W-1:0] rem2_reg;
    logic [E_W-1:0]    e2_reg;

    assign pos = POS_W'(f30_reg) * POS_W'(GAIN_TABLE_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_POS])
        begin
            tidx_reg <= IDX_W'(pos >> FRAC_W);
            rem2_reg <= pos[FRAC_W-1:0];
            e2_reg   <= e1_reg;
        end
    end

    // ---------------------------------------------------------------- log table read
    logic [LIDX_W-1:0] lo_addr;
    logic [LOG_W-1:0]  lo_next;
    logic [LOG_W-1:0]  diff_next;
    logic [LOG_W-1:0]  lo3_reg;
    logic [LOG_W-1:0]  diff_reg;
    logic [FRAC_W-1:0] rem3_reg;
    logic [E_W-1:0]    e3_reg;

    assign lo_addr   = LIDX_W'(tidx_reg);
    assign lo_next   = log_rom[lo_addr];
    assign diff_next = log_rom[lo_addr + LIDX_W'(1)] - lo_next;

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_LUT])
        begin
            lo3_reg  <= lo_next;
            diff_reg <= diff_next;
            rem3_reg <= rem2_reg;
            e3_reg   <= e2_reg;
        end
    end

    // ---------------------------------------------------------------- interpolation
    logic [IP_W-1:0]  ip_prod;
    logic [LOG_W-1:0] ip_reg;
    logic [LOG_W-1:0] lo4_reg;
    logic [E_W-1:0]   e4_reg;

    assign ip_prod = IP_W'(diff_reg) * IP_W'(rem3_reg);

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_INTERP])
        begin
            ip_reg  <= LOG_W'(ip_prod >> FRAC_W);
            lo4_reg <= lo3_reg;
            e4_reg  <= e3_reg;
        end
    end

    // ---------------------------------------------------------------- distance below full scale
    logic [LG_W-1:0] below_next;
    logic [LG_W-1:0] below_reg;

    assign below_next = BELOW_BASE - (LG_W'(e4_reg) << Q16_BITS)
                        - LG_W'(lo4_reg) - LG_W'(ip_reg);

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_BELOW])
            below_reg <= below_next;
    end

    // ---------------------------------------------------------------- log2 to dB
    logic [DPROD_W-1:0] dprod;
    logic [DEPTH_W-1:0] depth_reg;

    assign dprod = DPROD_W'(below_reg) * DPROD_W'(DB256_PER_LOG2) + DEPTH_ROUND;

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_DEPTH])
            depth_reg <= DEPTH_W'(dprod >> DEPTH_SHIFT);
    end

    // ---------------------------------------------------------------- threshold and slope
    logic signed [LEVEL_W-1:0] level;
    logic signed [LEVEL_W-1:0] thr;
    logic        [LEVEL_W-1:0] excess;
    logic        [RED_P_W-1:0] red_prod;
    logic                      hit_next;
    logic        [RED_W-1:0]   red_reg;

    always_comb
    begin
        level    = -$signed({1'b0, depth_reg});
        thr      = {threshold_reg[CFG_W-1], threshold_reg};
        hit_next = nz_reg[ST_CMP-1] && (level > thr);
        excess   = level - thr;
        red_prod = RED_P_W'(excess[RED_W-1:0]) * RED_P_W'(slope_reg);
    end

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_CMP])
        begin
            red_reg    <= red_prod[RED_P_W-1:RED_W];
            hit_reg[0] <= hit_next;
        end
    end

    // ---------------------------------------------------------------- dB to log2 units
    logic [RPROD_W-1:0] rprod;
    logic [R_W-1:0]     r_reg;

    assign rprod = RPROD_W'(red_reg) * RPROD_W'(LOG2_PER_DB256) + R_ROUND;

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_R])
            r_reg <= R_W'(rprod >> R_SHIFT);
    end

    // ---------------------------------------------------------------- exp table position
    logic [GP_W-1:0]  gp;
    logic [IDX_W-1:0] gidx_reg;
    logic [K_W-1:0]   k_reg;

    assign gp = GP_W'(r_reg[Q16_BITS-1:0]) * GP_W'(GAIN_TABLE_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_GIDX])
        begin
            gidx_reg <= IDX_W'(gp >> Q16_BITS);
            k_reg    <= K_W'(r_reg >> Q16_BITS);
        end
    end

    // ---------------------------------------------------------------- gain
    logic [GAIN_W-1:0] g_next;
    logic [GAIN_W-1:0] g_reg;

    // whole octaves of reduction become a right shift
    assign g_next = (k_reg > K_W'(GAIN_FRAC)) ? '0 : (exp_rom[gidx_reg] >> k_reg);

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_GAIN])
            g_reg <= g_next;
    end

    // ---------------------------------------------------------------- scale magnitude
    logic [SP_W-1:0] sprod;
    logic [S-1:0]    omag_reg;

    assign sprod = SP_W'(mag_reg[ST_SCALE-1]) * SP_W'(g_reg);

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_SCALE])
            omag_reg <= S'(sprod >> GAIN_FRAC);
    end

    // ---------------------------------------------------------------- output register
    logic [S-1:0] sample_next;
    logic [S-1:0] sample_out_reg;
    logic         reduced_reg;

    always_comb
    begin
        if (hit_reg[HIT_D-1])
            sample_next = neg_reg[RAW_D-1] ? (~omag_reg + 1'b1) : omag_reg;
        else
            sample_next = raw_reg[RAW_D-1];
    end

    always_ff @(posedge clk)
    begin
        if (pipe.load[ST_OUT])
        begin
            sample_out_reg <= sample_next;
            reduced_reg    <= hit_reg[HIT_D-1];
        end
    end

    assign sample_out     = sample_out_reg;
    assign was_reduced    = reduced_reg;
    assign frame_last_out = last_reg[LAST_D-1];

endmodule

`default_nettype wire

// ===== test/compressor_checker.sv =====
`timescale 1ns / 1ps
// compressor_checker: predicts each output word of the compressor from the words taken on
// its sample and config channels, then compares them field by field; depends on sdrc_pkg

module compressor_checker
    import sdrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] sample_in,
    input  logic        frame_last_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] sample_out,
    input  logic        was_reduced,
    input  logic        frame_last_out,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int LUT_N = 256;

    typedef struct packed {
        logic [15:0] sample;
        logic        reduced;
        logic        last;
    } comp_word_t;

    longint unsigned log2_lut [0:LUT_N];
    longint unsigned exp2_lut [0:LUT_N-1];

    logic signed [15:0] thr_copy;
    logic [15:0]        slope_copy;
    comp_word_t         expected_words [$];
    comp_word_t         oldest;

    // log2(1 + i/N) by squaring, 2^(-i/N) from chained square roots of one half
    initial
    begin : build_luts
        longint unsigned z;
        longint unsigned y;
        longint unsigned f;
        longint unsigned g;
        longint unsigned v;
        longint unsigned res;
        longint unsigned probe;
        longint unsigned roots [0:16];
        for (int i = 0; i < LUT_N; i++)
        begin
            z = (64'd1 << 30) + ((64'(i) << 30) / LUT_N);
            y = 0;
            for (int b = 15; b >= 0; b--)
            begin
                z = (z * z) >> 30;
                if (z >= (64'd2 << 30))
                begin
                    z = z >> 1;
                    y = y | (64'd1 << b);
                end
            end
            log2_lut[i] = y;
        end
        log2_lut[LUT_N] = 64'd65536;

        roots[0] = 64'd1 << 29;
        for (int b = 1; b <= 16; b++)
        begin
            v     = roots[b-1] << 30;
            res   = 0;
            probe = 64'd1 << 62;
            while (probe > v)
                probe = probe >> 2;
            while (probe != 0)
            begin
                if (v >= res + probe)
                begin
                    v   = v - (res + probe);
                    res = (res >> 1) + probe;
                end
                else
                begin
                    res = res >> 1;
                end
                probe = probe >> 2;
            end
            roots[b] = res;
        end

        for (int i = 0; i < LUT_N; i++)
        begin
            f = (64'(i) << 16) / LUT_N;
            g = 64'd1 << 30;
            for (int b = 1; b <= 16; b++)
            begin
                if (((f >> (16 - b)) & 64'd1) != 0)
                    g = (g * roots[b]) >> 30;
            end
            exp2_lut[i] = g;
        end
    end

    function automatic comp_word_t predict_compressed(input logic [15:0] raw, input logic last,
                                                      input logic signed [15:0] thr,
                                                      input logic [15:0] slope);
        longint unsigned mag;
        longint unsigned f30;
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned rem;
        longint unsigned lg;
        longint unsigned depth;
        longint unsigned red;
        longint unsigned r;
        longint unsigned k;
        longint unsigned g;
        longint unsigned omag;
        longint          level;
        int              e;
        comp_word_t      w;
        w.sample  = raw;
        w.reduced = 1'b0;
        w.last    = last;
        mag = raw[15] ? (64'd65536 - raw) : 64'(raw);
        if (mag != 0)
        begin
            e = 0;
            while ((mag >> (e + 1)) != 0)
                e++;
            f30 = (mag << (30 - e)) - (64'd1 << 30);
            pos = f30 * LUT_N;
            idx = pos >> 30;
            rem = pos & ((64'd1 << 30) - 1);
            if (idx >= LUT_N)
                idx = LUT_N - 1;
            lg = 64'(e) * 64'd65536 + log2_lut[idx]
                 + (((log2_lut[idx + 1] - log2_lut[idx]) * rem) >> 30);
            depth = (((64'd15 << 16) - lg) * 64'd394566 + (64'd1 << 23)) >> 24;
            level = -longint'(depth);
            if (level > longint'(thr))
            begin
                red  = (64'(level - longint'(thr)) * 64'(slope)) >> 16;
                r    = (red * 64'd2786635 + 64'd32768) >> 16;
                k    = r >> 16;
                idx  = ((r & 64'hFFFF) * LUT_N) >> 16;
                g    = (k > 30) ? 64'd0 : (exp2_lut[idx] >> k);
                omag = (mag * g) >> 30;
                w.sample  = raw[15] ? 16'(64'd65536 - omag) : 16'(omag);
                w.reduced = 1'b1;
            end
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_copy   = THRESHOLD_RESET;
            slope_copy = SLOPE_RESET;
            expected_words.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_THRESHOLD: thr_copy   = cfg_data;
                    REG_SLOPE:     slope_copy = cfg_data;
                endcase
            end
            if (in_valid && in_ready)
                expected_words.push_back(predict_compressed(sample_in, frame_last_in,
                                                            thr_copy, slope_copy));
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("output word with nothing expected: sample_out %0d",
                           $signed(sample_out));
                    fail_count++;
                end
                else
                begin
                    oldest = expected_words.pop_front();
                    if (sample_out !== oldest.sample)
                    begin
                        $error("sample_out: expected %0d, got %0d",
                               $signed(oldest.sample), $signed(sample_out));
                        fail_count++;
                    end
                    if (was_reduced !== oldest.reduced)
                    begin
                        $error("was_reduced: expected %0b, got %0b", oldest.reduced, was_reduced);
                        fail_count++;
                    end
                    if (frame_last_out !== oldest.last)
                    begin
                        $error("frame_last_out: expected %0b, got %0b",
                               oldest.last, frame_last_out);
                        fail_count++;
                    end
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: drives samples and register writes into the compressor core under random stalls;
// depends on sdrc_pkg, static_dynamic_range_compressor_core and compressor_checker

module tb
    import sdrc_pkg::*;
();

    localparam int HOLD_CYCLES        = 300;
    localparam int WATCHDOG_LIMIT     = 5000;
    localparam int RANDOM_PER_SETTING = 163;
    localparam int NUM_SETTINGS       = 6;
    localparam int SEND_IDLE [3] = '{11, 67, 0};
    localparam int RECV_IDLE [3] = '{67, 11, 0};

    // full scale, zero, one lsb, alternating bits and the -20 dBFS knee
    localparam logic [15:0] DIRECTED_WORDS [20] = '{
        16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h5555,
        16'hAAAA, 16'd3276, 16'd3277, 16'd3278, 16'hF333, 16'd3300, 16'd3250, 16'd100,
        16'hFF9C, 16'd2, 16'd32000, 16'h8001
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] sample_in;
    logic        frame_last_in;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] sample_out;
    logic        was_reduced;
    logic        frame_last_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    int idle_mode;
    int hold_reqs;
    int quiet_cycles;
    int fail_count;
    int pending;

    always #4 clk = ~clk;

    static_dynamic_range_compressor_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_in      (sample_in),
        .frame_last_in  (frame_last_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .was_reduced    (was_reduced),
        .frame_last_out (frame_last_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    compressor_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_in      (sample_in),
        .frame_last_in  (frame_last_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .was_reduced    (was_reduced),
        .frame_last_out (frame_last_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // ready is sampled at the falling edge, where it already holds its value for the next edge
    task automatic send_sample(input logic [15:0] s, input logic last);
        bit taken;
        while ($urandom_range(0, 99) < SEND_IDLE[idle_mode])
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        sample_in     <= s;
        frame_last_in <= last;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : out_side
        int holds_done;
        holds_done = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= RECV_IDLE[idle_mode]);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic signed [15:0] thr_set [NUM_SETTINGS];
        logic [15:0]        slope_set [NUM_SETTINGS];
        logic [15:0]        s;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        sample_in     <= '0;
        frame_last_in <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_THRESHOLD;
        cfg_data      <= '0;
        idle_mode = 0;
        hold_reqs = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings first
        for (int i = 0; i < 20; i++)
            send_sample(DIRECTED_WORDS[i], 1'(i % 2));
        drain();

        // threshold at 0 dBFS, deepest, deepest with no slope, above zero, most negative
        thr_set   = '{16'sh0000, -16'sd24576, -16'sd24576, 16'sh7FFF, -16'sd32768, 16'sh0000};
        slope_set = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'd49152, 16'h0000};
        thr_set[5]   = 16'(-int'($urandom_range(0, 24576)));
        slope_set[5] = 16'($urandom);

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            idle_mode = p / 2;
            write_reg(REG_THRESHOLD, thr_set[p]);
            write_reg(REG_SLOPE, slope_set[p]);
            cfg_valid <= 1'b0;
            // fill the pipeline against a stalled receiver
            if (p == 4)
                hold_reqs++;
            for (int n = 0; n < RANDOM_PER_SETTING; n++)
            begin
                if (p == 3 && n == RANDOM_PER_SETTING / 2)
                    drain();
                case ($urandom_range(0, 9)) inside
                    [0:3]: s = 16'($urandom);
                    [4:6]: s = 16'($signed(16'($urandom)) >>> $urandom_range(0, 15));
                    7:
                    begin
                        case ($urandom_range(0, 4))
                            0:       s = 16'h0000;
                            1:       s = 16'h7FFF;
                            2:       s = 16'h8000;
                            3:       s = 16'hFFFF;
                            default: s = 16'h0001;
                        endcase
                    end
                    default:
                    begin
                        s = 16'($urandom_range(24000, 32767));
                        if ($urandom_range(0, 1) == 1)
                            s = -s;
                    end
                endcase
                send_sample(s, 1'($urandom_range(0, 1)));
            end
            drain();
        end

        repeat (NUM_STAGES + 8) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sdrc_pkg.sv
sv/sdrc_ctrl.sv
sv/static_dynamic_range_compressor_core.sv
test/compressor_checker.sv
test/tb.sv
